// File: rtl/core/mext_pkg.sv
`timescale 1ns / 1ps
package mext_pkg;

  // Token kinds as they appear on the result channel
  typedef enum logic [2:0] {
    KIND_NUMBER   = 3'd0,
    KIND_OPERATOR = 3'd1,
    KIND_FUNCTION = 3'd2,
    KIND_VARIABLE = 3'd3,
    KIND_ERROR    = 3'd4
  } tok_kind_t;

  // Operator codes, in the order ( ) ^ * / + - =
  localparam logic [2:0] OP_LPAREN = 3'd0;
  localparam logic [2:0] OP_RPAREN = 3'd1;
  localparam logic [2:0] OP_POWER  = 3'd2;
  localparam logic [2:0] OP_MUL    = 3'd3;
  localparam logic [2:0] OP_DIV    = 3'd4;
  localparam logic [2:0] OP_ADD    = 3'd5;
  localparam logic [2:0] OP_SUB    = 3'd6;
  localparam logic [2:0] OP_EQUAL  = 3'd7;

  // Variable codes
  localparam logic [2:0] VAR_X = 3'd0;
  localparam logic [2:0] VAR_E = 3'd1;

  // Error codes
  localparam logic [2:0] ERR_LETTER = 3'd0;
  localparam logic [2:0] ERR_OTHER  = 3'd1;

  localparam logic [2:0] CODE_NONE = 3'd0;

  // Most tokens one character can release
  localparam int unsigned MaxBurst = 6;
  localparam int unsigned CountW   = $clog2(MaxBurst + 1);

  localparam logic [7:0] OpChars [8] = '{"(", ")", "^", "*", "/", "+", "-", "="};

  // Keywords, in function code order; "ln" is padded
  localparam logic [7:0] KwText [8][3] = '{
    '{"s", "i", "n"}, '{"c", "o", "s"}, '{"t", "a", "n"}, '{"s", "e", "c"},
    '{"c", "s", "c"}, '{"c", "o", "t"}, '{"l", "o", "g"}, '{"l", "n", 8'h00}
  };
  localparam logic [1:0] KwLen [8] = '{2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd2};

  typedef enum logic [1:0] {
    KW_NONE  = 2'd0,
    KW_FOUND = 2'd1,
    KW_WAIT  = 2'd2
  } kw_status_t;

  typedef struct packed {
    kw_status_t status;
    logic [2:0] index;
  } kw_hit_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] code;
  } op_hit_t;

  // One token of a burst; number payload rides in the descriptor
  typedef struct packed {
    tok_kind_t   kind;
    logic [2:0]  code;
    logic [7:0]  err_char;
    logic [15:0] err_pos;
  } tok_slot_t;

  // All tokens released by one character
  typedef struct packed {
    logic [CountW-1:0]           count;
    logic                        eos;
    logic [63:0]                 num_value;
    logic [7:0]                  num_digits;
    logic                        num_ovf;
    tok_slot_t [MaxBurst-1:0]    slots;
  } desc_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic op_hit_t op_lookup(input logic [7:0] c);
    op_hit_t r;
    r.hit  = 1'b0;
    r.code = CODE_NONE;
    for (int k = 0; k < 8; k++) begin
      if (!r.hit && (c == OpChars[k])) begin
        r.hit  = 1'b1;
        r.code = 3'(k);
      end
    end
    return r;
  endfunction

  // Compare one keyword against the window at the current letter
  function automatic kw_status_t kw_match(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic [7:0] b2, input logic [1:0] avail,
                                          input logic [2:0] k, input logic eos);
    logic [7:0] b [3];
    kw_status_t st;
    logic       done;
    b[0] = b0;
    b[1] = b1;
    b[2] = b2;
    st   = KW_FOUND;
    done = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (!done && (2'(i) < KwLen[k])) begin
        if (2'(i) >= avail) begin
          st   = eos ? KW_NONE : KW_WAIT;
          done = 1'b1;
        end else if (b[i] != KwText[k][i]) begin
          st   = KW_NONE;
          done = 1'b1;
        end
      end
    end
    return st;
  endfunction

  // First keyword that matches or still needs characters wins
  function automatic kw_hit_t kw_check(input logic [7:0] b0, input logic [7:0] b1,
                                       input logic [7:0] b2, input logic [1:0] avail,
                                       input logic eos);
    kw_hit_t    r;
    kw_status_t m;
    logic       done;
    r.status = KW_NONE;
    r.index  = '0;
    done     = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if (!done) begin
        m = kw_match(b0, b1, b2, avail, 3'(k), eos);
        if (m == KW_WAIT) begin
          r.status = KW_WAIT;
          done     = 1'b1;
        end else if (m == KW_FOUND) begin
          r.status = KW_FOUND;
          r.index  = 3'(k);
          done     = 1'b1;
        end
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/core/mext_stream_if.sv
`timescale 1ns / 1ps
// Character channel
interface mext_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_string;

  modport source(output valid, output character, output end_of_string, input ready);
  modport sink(input valid, input character, input end_of_string, output ready);
endinterface

// Token channel
interface mext_token_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [2:0]  token_code;
  logic [63:0] number_value;
  logic [7:0]  digit_count;
  logic        number_overflow;
  logic [7:0]  error_char;
  logic [15:0] error_position;
  logic        last_of_run;
  logic        string_end;

  modport source(output valid, output token_kind, output token_code, output number_value,
                 output digit_count, output number_overflow, output error_char,
                 output error_position, output last_of_run, output string_end, input ready);
  modport sink(input valid, input token_kind, input token_code, input number_value,
               input digit_count, input number_overflow, input error_char,
               input error_position, input last_of_run, input string_end, output ready);
endinterface

// File: rtl/core/mext_front.sv
`timescale 1ns / 1ps
module mext_front #(
  parameter logic [15:0] POS_CAP = 16'hFFFF
) (
  input  logic            clk,
  input  logic            rst,
  mext_char_if.sink       chars,
  input  logic            full,
  output logic            push,
  output mext_pkg::desc_t push_data
);

  localparam int unsigned WinDepth = 5;
  localparam int unsigned CountW   = mext_pkg::CountW;

  // Lookahead, number and position state
  logic [7:0]  pend [2];
  logic [1:0]  pend_cnt;
  logic        in_num;
  logic [63:0] acc;
  logic [7:0]  dig;
  logic        ovf;
  logic [15:0] pos;

  logic [7:0]  pend_next [2];
  logic [1:0]  pend_cnt_next;
  logic        in_num_next;
  logic [15:0] pos_next;

  logic        accept;
  logic        eos;
  logic        c_digit;
  logic        flush_first;
  logic        saturated;
  logic [7:0]  win_ch [WinDepth];
  logic [15:0] win_pos [3];
  logic [1:0]  win_len;

  logic [63:0] base_acc;
  logic [7:0]  base_dig;
  logic        base_ovf;
  logic [67:0] scaled;
  logic [63:0] step_acc;
  logic [7:0]  step_dig;
  logic        step_ovf;

  mext_pkg::desc_t   desc;
  mext_pkg::kw_hit_t hit;
  mext_pkg::op_hit_t oph;
  mext_pkg::op_hit_t oph_next;
  logic [CountW-1:0] n_tok;
  logic [1:0]        skip;
  logic              stop;
  logic [1:0]        wait_idx;

  function automatic mext_pkg::tok_slot_t mk_slot(input mext_pkg::tok_kind_t kind,
                                                  input logic [2:0] code,
                                                  input logic [7:0] ch,
                                                  input logic [15:0] p);
    mext_pkg::tok_slot_t s;
    s.kind     = kind;
    s.code     = code;
    s.err_char = ch;
    s.err_pos  = p;
    return s;
  endfunction

  assign eos         = chars.end_of_string;
  assign accept      = chars.valid && !full;
  assign chars.ready = !full;
  assign c_digit     = mext_pkg::is_digit(chars.character);
  assign flush_first = in_num && !c_digit;
  assign saturated   = pos >= POS_CAP;

  // Build the window: held letters, then the new character
  always_comb begin
    win_ch[0] = (pend_cnt != 2'd0) ? pend[0] : chars.character;
    win_ch[1] = (pend_cnt == 2'd2) ? pend[1] : chars.character;
    win_ch[2] = chars.character;
    win_ch[3] = '0;
    win_ch[4] = '0;
    win_len   = pend_cnt + 2'd1;
    for (int i = 0; i < 3; i++) begin
      win_pos[i] = saturated ? POS_CAP : (pos - 16'(pend_cnt) + 16'(i));
    end
  end

  // Extend the running number by the new digit, saturating
  always_comb begin
    base_acc = in_num ? acc : '0;
    base_dig = in_num ? dig : '0;
    base_ovf = in_num ? ovf : 1'b0;
    scaled   = ({4'b0, base_acc} << 3) + ({4'b0, base_acc} << 1)
               + 68'(chars.character[3:0]);
    step_acc = (scaled[67:64] != 4'd0) ? '1 : scaled[63:0];
    step_dig = (base_dig == 8'hFF) ? base_dig : base_dig + 8'd1;
    step_ovf = base_ovf || (scaled[67:64] != 4'd0) || (base_dig == 8'hFF);
  end

  // Resolve the window front to back into a burst of tokens
  always_comb begin
    desc     = '0;
    n_tok    = '0;
    skip     = '0;
    stop     = 1'b0;
    wait_idx = win_len;
    hit      = '0;
    oph      = '0;
    oph_next = '0;
    if (flush_first) begin
      desc.slots[n_tok] = mk_slot(mext_pkg::KIND_NUMBER, mext_pkg::CODE_NONE, '0, '0);
      n_tok = n_tok + CountW'(1);
    end
    for (int i = 0; i < 3; i++) begin
      if ((2'(i) < win_len) && !stop) begin
        oph = mext_pkg::op_lookup(win_ch[i]);
        if (skip != 2'd0) begin
          // drop letters eaten by a keyword
          skip = skip - 2'd1;
        end else if (mext_pkg::is_letter(win_ch[i])) begin
          hit = mext_pkg::kw_check(win_ch[i], win_ch[i+1], win_ch[i+2],
                                   win_len - 2'(i), eos);
          if (hit.status == mext_pkg::KW_WAIT) begin
            stop     = 1'b1;
            wait_idx = 2'(i);
          end else if (hit.status == mext_pkg::KW_FOUND) begin
            desc.slots[n_tok] = mk_slot(mext_pkg::KIND_FUNCTION, hit.index, '0, '0);
            n_tok = n_tok + CountW'(1);
            skip  = mext_pkg::KwLen[hit.index] - 2'd1;
          end else if ((win_ch[i] == "x") || (win_ch[i] == "e")) begin
            if ((2'(i + 1) >= win_len) && !eos) begin
              // hold the variable until its follower is known
              stop     = 1'b1;
              wait_idx = 2'(i);
            end else begin
              desc.slots[n_tok] = mk_slot(mext_pkg::KIND_OPERATOR, mext_pkg::OP_MUL, '0, '0);
              n_tok = n_tok + CountW'(1);
              desc.slots[n_tok] = mk_slot(mext_pkg::KIND_VARIABLE,
                                          (win_ch[i] == "x") ? mext_pkg::VAR_X
                                                             : mext_pkg::VAR_E, '0, '0);
              n_tok = n_tok + CountW'(1);
              oph_next = mext_pkg::op_lookup(win_ch[i+1]);
              if ((2'(i + 1) < win_len) && !oph_next.hit) begin
                desc.slots[n_tok] = mk_slot(mext_pkg::KIND_OPERATOR, mext_pkg::OP_MUL,
                                            '0, '0);
                n_tok = n_tok + CountW'(1);
              end
            end
          end else begin
            desc.slots[n_tok] = mk_slot(mext_pkg::KIND_ERROR, mext_pkg::ERR_LETTER,
                                        win_ch[i], win_pos[i]);
            n_tok = n_tok + CountW'(1);
          end
        end else if (oph.hit) begin
          desc.slots[n_tok] = mk_slot(mext_pkg::KIND_OPERATOR, oph.code, '0, '0);
          n_tok = n_tok + CountW'(1);
        end else if (!mext_pkg::is_digit(win_ch[i])) begin
          desc.slots[n_tok] = mk_slot(mext_pkg::KIND_ERROR, mext_pkg::ERR_OTHER,
                                      win_ch[i], win_pos[i]);
          n_tok = n_tok + CountW'(1);
        end
      end
    end
    // close an open number at the end of the string
    if (eos && c_digit) begin
      desc.slots[n_tok] = mk_slot(mext_pkg::KIND_NUMBER, mext_pkg::CODE_NONE, '0, '0);
      n_tok = n_tok + CountW'(1);
    end
    desc.count      = n_tok;
    desc.eos        = eos;
    desc.num_value  = flush_first ? acc : step_acc;
    desc.num_digits = flush_first ? dig : step_dig;
    desc.num_ovf    = flush_first ? ovf : step_ovf;
  end

  assign push      = accept && (n_tok != '0);
  assign push_data = desc;

  // Next lookahead and position
  always_comb begin
    pend_next[0]  = win_ch[3'(wait_idx)];
    pend_next[1]  = win_ch[3'(wait_idx) + 3'd1];
    pend_cnt_next = eos ? 2'd0 : (win_len - wait_idx);
    in_num_next   = c_digit && !eos;
    pos_next      = eos ? 16'd0 : (saturated ? pos : pos + 16'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_cnt <= '0;
      in_num   <= 1'b0;
      pos      <= '0;
    end else if (accept) begin
      pend_cnt <= pend_cnt_next;
      in_num   <= in_num_next;
      pos      <= pos_next;
    end
  end

  // Payload state, qualified by in_num and pend_cnt
  always_ff @(posedge clk) begin
    if (accept) begin
      pend <= pend_next;
      acc  <= step_acc;
      dig  <= step_dig;
      ovf  <= step_ovf;
    end
  end

endmodule

// File: rtl/core/mext_queue.sv
`timescale 1ns / 1ps
module mext_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mext_pkg::desc_t push_data,
  output logic            full,
  input  logic            pop,
  output mext_pkg::desc_t head,
  output logic            head_valid
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);

  mext_pkg::desc_t       entries [Depth];
  logic [PtrW-1:0]       wr_ptr;
  logic [PtrW-1:0]       rd_ptr;
  logic [PtrW:0]         fill;

  assign full       = fill == (PtrW + 1)'(Depth);
  assign head_valid = fill != '0;
  assign head       = entries[rd_ptr];

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        fill <= fill + (PtrW + 1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (PtrW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// File: rtl/core/mext_back.sv
`timescale 1ns / 1ps
module mext_back (
  input  logic            clk,
  input  logic            rst,
  input  mext_pkg::desc_t head,
  input  logic            head_valid,
  output logic            pop,
  mext_token_if.source    tokens
);

  localparam int unsigned CountW = mext_pkg::CountW;

  logic [CountW-1:0]   idx;
  mext_pkg::tok_slot_t cur;
  logic                load;
  logic                last;
  logic                is_num;

  logic                out_valid;
  mext_pkg::tok_kind_t out_kind;
  logic [2:0]          out_code;
  logic [63:0]         out_value;
  logic [7:0]          out_digits;
  logic                out_ovf;
  logic [7:0]          out_char;
  logic [15:0]         out_pos;
  logic                out_last;
  logic                out_end;

  assign cur    = head.slots[idx];
  assign is_num = cur.kind == mext_pkg::KIND_NUMBER;
  assign last   = idx == (head.count - CountW'(1));
  assign load   = head_valid && (!out_valid || tokens.ready);
  assign pop    = load && last;

  // Step through the burst, one beat per cycle while the output is empty or taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= last ? '0 : idx + CountW'(1);
    end else if (tokens.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Load the output beat
  always_ff @(posedge clk) begin
    if (load) begin
      out_kind   <= cur.kind;
      out_code   <= cur.code;
      out_value  <= is_num ? head.num_value : '0;
      out_digits <= is_num ? head.num_digits : '0;
      out_ovf    <= is_num && head.num_ovf;
      out_char   <= cur.err_char;
      out_pos    <= cur.err_pos;
      out_last   <= last;
      out_end    <= last && head.eos;
    end
  end

  assign tokens.valid           = out_valid;
  assign tokens.token_kind      = out_kind;
  assign tokens.token_code      = out_code;
  assign tokens.number_value    = out_value;
  assign tokens.digit_count     = out_digits;
  assign tokens.number_overflow = out_ovf;
  assign tokens.error_char      = out_char;
  assign tokens.error_position  = out_pos;
  assign tokens.last_of_run     = out_last;
  assign tokens.string_end      = out_end;

endmodule

// File: rtl/core/math_expression_tokenizer.sv
`timescale 1ns / 1ps
// Streaming tokenizer: takes one expression character per beat on chars and
// returns numbers, operators, functions, variables and error tokens on tokens,
// one token per beat, with last_of_run on the final token a character caused
// and string_end on the final token of the expression. The front classifies a
// character in the cycle it is taken and pushes its whole burst of tokens into
// a two-entry queue; the back reads a burst out at one token per cycle while
// tokens.ready allows, through a registered output stage. A character is taken
// every cycle while the queue has room, so the back's one-token-per-cycle drain
// sets the sustained rate; a single character yields at most six tokens. The
// first token of a character is written into the queue and then into the
// registered output stage before it appears on the output.
module math_expression_tokenizer #(
  parameter int unsigned MAX_LENGTH = 65535
) (
  input  logic          clk,
  input  logic          rst,
  mext_char_if.sink     chars,
  mext_token_if.source  tokens
);

  localparam logic [15:0] PosCap = (MAX_LENGTH < 32'd65535) ? 16'(MAX_LENGTH) : 16'hFFFF;

  logic            q_push;
  mext_pkg::desc_t q_push_data;
  logic            q_full;
  logic            q_pop;
  mext_pkg::desc_t q_head;
  logic            q_head_valid;

  mext_front #(
    .POS_CAP(PosCap)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .chars    (chars),
    .full     (q_full),
    .push     (q_push),
    .push_data(q_push_data)
  );

  mext_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .head_valid(q_head_valid)
  );

  mext_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .head_valid(q_head_valid),
    .pop       (q_pop),
    .tokens    (tokens)
  );

  // Queued bursts are never empty and never exceed the slot count
  assert property (@(posedge clk) disable iff (rst)
    q_head_valid |-> (q_head.count != '0) &&
                     (q_head.count <= mext_pkg::CountW'(mext_pkg::MaxBurst)))
    else $error("burst count out of range");

  // The end of the expression closes a run
  assert property (@(posedge clk) disable iff (rst)
    tokens.valid && tokens.string_end |-> tokens.last_of_run)
    else $error("string_end without last_of_run");

  // Error positions stay at or below the cap
  assert property (@(posedge clk) disable iff (rst)
    tokens.valid && (tokens.token_kind == mext_pkg::KIND_ERROR) |->
      tokens.error_position <= PosCap)
    else $error("error position above cap");

  // Number fields are zero on every other kind
  assert property (@(posedge clk) disable iff (rst)
    tokens.valid && (tokens.token_kind != mext_pkg::KIND_NUMBER) |->
      (tokens.number_value == '0) && (tokens.digit_count == '0) && !tokens.number_overflow)
    else $error("number fields set on a non-number token");

endmodule
